[design/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the point clamp block
// Q16.16 limits, register indexes and the words carried along the cell chains
// ----------------------------------------------------------------------------
package pcc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SHAPE_MODE  = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HALF_HEIGHT = 2'd2;

  // shape codes
  localparam logic SHAPE_UNIT = 1'b0;
  localparam logic SHAPE_BOX  = 1'b1;

  // extent limits, 0.05 and 1.0 in Q16.16
  localparam logic [16:0] EXT_MIN = 17'd3277;
  localparam logic [16:0] EXT_MAX = 17'd65536;
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  // one result bit per cell
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  // point magnitudes and signs, carried alongside the root chain
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic        nx;
    logic        ny;
    logic        map_view;
  } side_t;

  // root chain word: radicand bits still to consume, remainder, partial root
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // one divider lane: dividend bits still to consume, partial remainder,
  // divisor and partial quotient
  typedef struct packed {
    logic [16:0] num;
    logic [31:0] p;
    logic [31:0] d;
    logic [16:0] q;
  } lane_t;

  // output selection carried alongside the divider chain
  typedef struct packed {
    logic        nx;
    logic        ny;
    logic        use_qx;
    logic        use_qy;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] rdist;
  } side2_t;

endpackage

[design/point_clamp_circle_or_rect.sv]
// ----------------------------------------------------------------------------
// point_clamp_circle_or_rect: limits a Q16.16 point to a circle or a box
// Reports the raw distance and scales the point onto the limit shape
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the output is held, set by a 32-cell root chain
// followed by a 17-cell two-lane divider chain, all advancing together
// a stalled output word holds the whole pipeline
// reset clears all valid flags and restores shape 0 and extents of 1.0
module point_clamp_circle_or_rect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic        map_view_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic        en;
  logic        shape_q;
  logic [16:0] half_w_q, half_h_q;
  logic [16:0] cfg_sat;

  // front stages
  logic            v1_q, v2_q, v3_q;
  pcc_pkg::side_t  side1_q, side2_q, side3_q;
  logic [63:0]     sqx_q, sqy_q;
  logic [63:0]     rad3_q;

  // root chain
  logic            sv   [0:pcc_pkg::SQRT_STEPS];
  pcc_pkg::sq_t    sq   [0:pcc_pkg::SQRT_STEPS];
  pcc_pkg::side_t  sside[0:pcc_pkg::SQRT_STEPS];

  // setup stages
  logic            v4_q, v5_q;
  pcc_pkg::side_t  side4_q;
  logic [31:0]     dist4_q;
  logic [48:0]     axh_q, ayw_q;
  logic            outside_q, circ_q;
  pcc_pkg::lane_t  lx5_d, ly5_d, lx5_q, ly5_q;
  pcc_pkg::side2_t s25_d, s25_q;
  logic            clamp_c, clamp_r, xdom;

  // divider chain
  logic            dv   [0:pcc_pkg::DIV_STEPS];
  pcc_pkg::lane_t  dlx  [0:pcc_pkg::DIV_STEPS];
  pcc_pkg::lane_t  dly  [0:pcc_pkg::DIV_STEPS];
  pcc_pkg::side2_t dside[0:pcc_pkg::DIV_STEPS];

  // output register
  logic            out_valid_q;
  logic [31:0]     out_x_q, out_y_q, dist_q;
  logic [31:0]     mag_x, mag_y;
  pcc_pkg::side2_t ls;

  // the whole pipeline moves unless a finished word is held
  assign en          = !(out_valid_q && !out_ready_i);
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // extent saturation on write
  always_comb begin
    if (cfg_data_i < pcc_pkg::EXT_MIN) begin
      cfg_sat = pcc_pkg::EXT_MIN;
    end else if (cfg_data_i > pcc_pkg::EXT_MAX) begin
      cfg_sat = pcc_pkg::EXT_MAX;
    end else begin
      cfg_sat = cfg_data_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= pcc_pkg::SHAPE_UNIT;
      half_w_q <= pcc_pkg::EXT_MAX;
      half_h_q <= pcc_pkg::EXT_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcc_pkg::REG_SHAPE_MODE:  shape_q  <= cfg_data_i[0];
        pcc_pkg::REG_HALF_WIDTH:  half_w_q <= cfg_sat;
        pcc_pkg::REG_HALF_HEIGHT: half_h_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // front valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // magnitudes, squares, sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q.nx       <= in_x_i[31];
      side1_q.ny       <= in_y_i[31];
      side1_q.ax       <= in_x_i[31] ? 32'(-in_x_i) : in_x_i;
      side1_q.ay       <= in_y_i[31] ? 32'(-in_y_i) : in_y_i;
      side1_q.map_view <= map_view_i;
      sqx_q            <= {32'd0, side1_q.ax} * {32'd0, side1_q.ax};
      sqy_q            <= {32'd0, side1_q.ay} * {32'd0, side1_q.ay};
      side2_q          <= side1_q;
      rad3_q           <= sqx_q + sqy_q;
      side3_q          <= side2_q;
    end
  end

  // root chain
  assign sv[0]       = v3_q;
  assign sq[0].rad   = rad3_q;
  assign sq[0].rem   = '0;
  assign sq[0].root  = '0;
  assign sside[0]    = side3_q;

  for (genvar i = 0; i < pcc_pkg::SQRT_STEPS; i++) begin : g_sqrt
    pcc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[i]),
      .sq_i    (sq[i]),
      .side_i  (sside[i]),
      .valid_o (sv[i+1]),
      .sq_o    (sq[i+1]),
      .side_o  (sside[i+1])
    );
  end

  // setup valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v4_q <= sv[pcc_pkg::SQRT_STEPS];
      v5_q <= v4_q;
    end
  end

  // cross products and limit tests
  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q   <= sside[pcc_pkg::SQRT_STEPS];
      dist4_q   <= sq[pcc_pkg::SQRT_STEPS].root;
      axh_q     <= {17'd0, sside[pcc_pkg::SQRT_STEPS].ax} * {32'd0, half_h_q};
      ayw_q     <= {17'd0, sside[pcc_pkg::SQRT_STEPS].ay} * {32'd0, half_w_q};
      outside_q <= (sside[pcc_pkg::SQRT_STEPS].ax > {15'd0, half_w_q}) ||
                   (sside[pcc_pkg::SQRT_STEPS].ay > {15'd0, half_h_q});
      circ_q    <= (sq[pcc_pkg::SQRT_STEPS].root > pcc_pkg::ONE_Q16);
    end
  end

  // lane setup: pick dividend, divisor and fallback per axis
  always_comb begin
    clamp_c = !side4_q.map_view && (shape_q == pcc_pkg::SHAPE_UNIT) && circ_q;
    clamp_r = !side4_q.map_view && (shape_q == pcc_pkg::SHAPE_BOX) && outside_q;
    xdom    = (axh_q >= ayw_q);

    lx5_d = '0;
    ly5_d = '0;
    lx5_d.d = 32'd1;
    ly5_d.d = 32'd1;
    s25_d.nx     = side4_q.nx;
    s25_d.ny     = side4_q.ny;
    s25_d.use_qx = 1'b0;
    s25_d.use_qy = 1'b0;
    s25_d.fx     = side4_q.ax;
    s25_d.fy     = side4_q.ay;
    s25_d.rdist  = dist4_q;

    if (clamp_c) begin
      lx5_d.p      = {1'b0, side4_q.ax[31:1]};
      lx5_d.num    = {side4_q.ax[0], 16'd0};
      lx5_d.d      = dist4_q;
      ly5_d.p      = {1'b0, side4_q.ay[31:1]};
      ly5_d.num    = {side4_q.ay[0], 16'd0};
      ly5_d.d      = dist4_q;
      s25_d.use_qx = 1'b1;
      s25_d.use_qy = 1'b1;
    end else if (clamp_r) begin
      if (xdom) begin
        ly5_d.p      = ayw_q[48:17];
        ly5_d.num    = ayw_q[16:0];
        ly5_d.d      = side4_q.ax;
        s25_d.use_qy = 1'b1;
        s25_d.fx     = {15'd0, half_w_q};
      end else begin
        lx5_d.p      = axh_q[48:17];
        lx5_d.num    = axh_q[16:0];
        lx5_d.d      = side4_q.ay;
        s25_d.use_qx = 1'b1;
        s25_d.fy     = {15'd0, half_h_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lx5_q <= lx5_d;
      ly5_q <= ly5_d;
      s25_q <= s25_d;
    end
  end

  // divider chain
  assign dv[0]    = v5_q;
  assign dlx[0]   = lx5_q;
  assign dly[0]   = ly5_q;
  assign dside[0] = s25_q;

  for (genvar j = 0; j < pcc_pkg::DIV_STEPS; j++) begin : g_div
    pcc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .lx_i    (dlx[j]),
      .ly_i    (dly[j]),
      .side_i  (dside[j]),
      .valid_o (dv[j+1]),
      .lx_o    (dlx[j+1]),
      .ly_o    (dly[j+1]),
      .side_o  (dside[j+1])
    );
  end

  // final magnitude and sign
  always_comb begin
    ls    = dside[pcc_pkg::DIV_STEPS];
    mag_x = ls.use_qx ? {15'd0, dlx[pcc_pkg::DIV_STEPS].q} : ls.fx;
    mag_y = ls.use_qy ? {15'd0, dly[pcc_pkg::DIV_STEPS].q} : ls.fy;
  end

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[pcc_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= ls.nx ? 32'(-mag_x) : mag_x;
      out_y_q <= ls.ny ? 32'(-mag_y) : mag_y;
      dist_q  <= ls.rdist;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign distance_o  = dist_q;

endmodule

[design/pcc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pcc_sqrt_cell: one step of the integer square root chain
// Takes two radicand bits, settles one root bit and passes on the word
// ----------------------------------------------------------------------------
module pcc_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pcc_pkg::sq_t    sq_i,
  input  pcc_pkg::side_t  side_i,
  output logic            valid_o,
  output pcc_pkg::sq_t    sq_o,
  output pcc_pkg::side_t  side_o
);

  logic           valid_q;
  pcc_pkg::sq_t   sq_d, sq_q;
  pcc_pkg::side_t side_q;
  logic [35:0]    rem_ext;
  logic [35:0]    trial;
  logic           ge;

  // restoring step: bring down two bits, try root*4+1
  always_comb begin
    rem_ext     = {sq_i.rem, sq_i.rad[63:62]};
    trial       = {2'b00, sq_i.root, 2'b01};
    ge          = (rem_ext >= trial);
    sq_d.rad    = {sq_i.rad[61:0], 2'b00};
    sq_d.rem    = ge ? 34'(rem_ext - trial) : rem_ext[33:0];
    sq_d.root   = {sq_i.root[30:0], ge};
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // word registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign side_o  = side_q;

endmodule

[design/pcc_div_cell.sv]
// ----------------------------------------------------------------------------
// pcc_div_cell: one step of the two-lane divider chain
// Settles one quotient bit in each of the x and y lanes
// ----------------------------------------------------------------------------
module pcc_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pcc_pkg::lane_t   lx_i,
  input  pcc_pkg::lane_t   ly_i,
  input  pcc_pkg::side2_t  side_i,
  output logic             valid_o,
  output pcc_pkg::lane_t   lx_o,
  output pcc_pkg::lane_t   ly_o,
  output pcc_pkg::side2_t  side_o
);

  logic            valid_q;
  pcc_pkg::lane_t  lx_q, ly_q;
  pcc_pkg::side2_t side_q;

  // restoring division step on one lane
  function automatic pcc_pkg::lane_t div_step(input pcc_pkg::lane_t l);
    pcc_pkg::lane_t r;
    logic [32:0]    pt;
    logic           ge;
    pt    = {l.p, l.num[16]};
    ge    = (pt >= {1'b0, l.d});
    r.p   = ge ? 32'(pt - {1'b0, l.d}) : pt[31:0];
    r.num = {l.num[15:0], 1'b0};
    r.d   = l.d;
    r.q   = {l.q[15:0], ge};
    return r;
  endfunction

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // lane registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q   <= div_step(lx_i);
      ly_q   <= div_step(ly_i);
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign lx_o    = lx_q;
  assign ly_o    = ly_q;
  assign side_o  = side_q;

endmodule

[design/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks for the point clamp block
// Watches the handshakes and the bound between result and distance
// ----------------------------------------------------------------------------
module pcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] distance_o
);

  logic [31:0] mag_x, mag_y;

  assign mag_x = out_x_o[31] ? 32'(-out_x_o) : out_x_o;
  assign mag_y = out_y_o[31] ? 32'(-out_y_o) : out_y_o;

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) &&
    $stable(out_y_o) && $stable(distance_o))
    else $error("output word changed while held");

  // input side only stalls behind a held output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // a limited coordinate never exceeds the raw distance
  a_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mag_x <= distance_o)
    else $error("x magnitude above distance");

  a_y_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mag_y <= distance_o)
    else $error("y magnitude above distance");

endmodule

bind point_clamp_circle_or_rect pcc_checker u_pcc_checker (.*);

[tb/sv/point_clamp_circle_or_rect_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_clamp_circle_or_rect_tb: self-checking bench for the point clamp block
// Streams Q16.16 points through the block under several shape and extent
// settings, predicts distance and clamped point per word and compares them
// in order, with random stalls on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module point_clamp_circle_or_rect_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 100;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] rdist;
  } clamp_word_t;

  // expected clamp results, oldest first
  class point_scoreboard;
    clamp_word_t pending[$];
    int errors = 0;

    function logic [31:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        cand = r | (64'd1 << i);
        if (cand * cand <= v) r = cand;
      end
      return r[31:0];
    endfunction

    function logic [31:0] signed_word(logic neg, logic [63:0] mag);
      logic [31:0] m;
      m = mag[31:0];
      return neg ? -m : m;
    endfunction

    // work out distance and limited point of one input word
    function void note_point(logic [31:0] x, logic [31:0] y, logic map_v,
                             logic mode, logic [16:0] w, logic [16:0] h);
      logic [63:0] ax, ay, ox, oy, d;
      clamp_word_t e;
      ax = x[31] ? 64'h1_0000_0000 - {32'd0, x} : {32'd0, x};
      ay = y[31] ? 64'h1_0000_0000 - {32'd0, y} : {32'd0, y};
      d = {32'd0, root_floor(ax * ax + ay * ay)};
      ox = ax;
      oy = ay;
      if (!map_v) begin
        if (mode == pcc_pkg::SHAPE_UNIT) begin
          if (d > pcc_pkg::ONE_Q16) begin
            ox = (ax << 16) / d;
            oy = (ay << 16) / d;
          end
        end else if (ax > w || ay > h) begin
          // ties pick x as the dominant axis
          if (ax * h >= ay * w) begin
            oy = (ay * w) / ax;
            ox = w;
          end else begin
            ox = (ax * h) / ay;
            oy = h;
          end
        end
      end
      e.x = signed_word(x[31], ox);
      e.y = signed_word(y[31], oy);
      e.rdist = d[31:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] d);
      clamp_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word x=%h y=%h dist=%h", $time, x, y, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $display("%0t: out_x expected %h actual %h", $time, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: out_y expected %h actual %h", $time, e.y, y);
        errors++;
      end
      if (d !== e.rdist) begin
        $display("%0t: distance expected %h actual %h", $time, e.rdist, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic [31:0] in_x = 0;
  logic [31:0] in_y = 0;
  logic        map_view = 0;
  logic        out_ready = 0;
  logic        cfg_valid = 0;
  logic [1:0]  cfg_index = 0;
  logic [16:0] cfg_data = 0;
  logic        in_ready, out_valid, cfg_ready;
  logic [31:0] out_x, out_y, distance;

  // bench copy of the registers
  logic        shape = pcc_pkg::SHAPE_UNIT;
  logic [16:0] half_w = pcc_pkg::EXT_MAX;
  logic [16:0] half_h = pcc_pkg::EXT_MAX;

  bit hold_req = 0;
  bit calm = 0;
  int idle_cycles = 0;
  point_scoreboard sb = new();

  point_clamp_circle_or_rect u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_x_i      (in_x),
    .in_y_i      (in_y),
    .map_view_i  (map_view),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .distance_o  (distance),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function logic [16:0] clip_extent(logic [16:0] v);
    if (v < pcc_pkg::EXT_MIN) return pcc_pkg::EXT_MIN;
    if (v > pcc_pkg::EXT_MAX) return pcc_pkg::EXT_MAX;
    return v;
  endfunction

  // one register write, then keep the bench copy in step
  task cfg_write(logic [1:0] idx, logic [16:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      pcc_pkg::REG_SHAPE_MODE: begin
        shape = data[0];
      end
      pcc_pkg::REG_HALF_WIDTH: begin
        half_w = clip_extent(data);
      end
      pcc_pkg::REG_HALF_HEIGHT: begin
        half_h = clip_extent(data);
      end
      default: begin
      end
    endcase
  endtask

  // offer one point word and note it once accepted
  task send_point(logic [31:0] x, logic [31:0] y, logic map_v);
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    map_view <= map_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(x, y, map_v, shape, half_w, half_h);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // stop offering, then wait for every expected word
  task wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // corners, extremes and boundary points under the current setting
  task send_directed();
    logic [31:0] w32, h32;
    w32 = {15'd0, half_w};
    h32 = {15'd0, half_h};
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(pcc_pkg::ONE_Q16, 32'd0, 1'b0);
    send_point(pcc_pkg::ONE_Q16 + 32'd1, 32'd0, 1'b0);
    send_point(32'd0, -pcc_pkg::ONE_Q16, 1'b0);
    send_point(w32, -h32, 1'b0);
    send_point(-(w32 + 32'd1), h32, 1'b0);
    send_point(w32 * 32'd2, -(h32 * 32'd2), 1'b0);
    send_point(32'd5, 32'd300000, 1'b0);
    send_point(32'h8000_0000, 32'h1234_5678, 1'b1);
  endtask

  task send_random(int count);
    logic [31:0] x, y;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        x = 32'($urandom_range(0, 393216) - 196608);
        y = 32'($urandom_range(0, 393216) - 196608);
      end else if (kind < 8) begin
        x = $urandom;
        y = $urandom;
      end else begin
        // points right on or next to the box edge
        x = 32'({15'd0, half_w} + $urandom_range(0, 2) - 1);
        y = $urandom_range(0, {15'd0, half_h});
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
      end
      send_point(x, y, $urandom_range(0, 4) == 0);
    end
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        hold_req = 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_x, out_y, distance);
      if ((out_valid && out_ready) || (in_valid && in_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset setting: unit circle
    send_directed();
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // full-size box
    cfg_write(pcc_pkg::REG_SHAPE_MODE, {16'd0, pcc_pkg::SHAPE_BOX});
    cfg_write(pcc_pkg::REG_HALF_WIDTH, pcc_pkg::EXT_MAX);
    cfg_write(pcc_pkg::REG_HALF_HEIGHT, pcc_pkg::EXT_MAX);
    send_directed();
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // out-of-range extents saturate, unused index is ignored
    cfg_write(pcc_pkg::REG_HALF_WIDTH, 17'd0);
    cfg_write(pcc_pkg::REG_HALF_HEIGHT, 17'h1ffff);
    cfg_write(REG_UNUSED, 17'h1ffff);
    send_directed();
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // random extents, output held off so the pipe fills
    cfg_write(pcc_pkg::REG_HALF_WIDTH, 17'($urandom));
    cfg_write(pcc_pkg::REG_HALF_HEIGHT, 17'($urandom));
    hold_req = 1;
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // back to circle with odd extents left behind
    cfg_write(pcc_pkg::REG_SHAPE_MODE, 17'($urandom) & 17'h1fffe);
    cfg_write(pcc_pkg::REG_HALF_WIDTH, pcc_pkg::EXT_MIN);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // narrow box, no random stalls in this last phase
    cfg_write(pcc_pkg::REG_SHAPE_MODE, {16'd0, pcc_pkg::SHAPE_BOX});
    cfg_write(pcc_pkg::REG_HALF_HEIGHT,
              17'($urandom_range(pcc_pkg::EXT_MIN, pcc_pkg::EXT_MAX)));
    calm = 1;
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
